// ----- rtl/jse_pkg.sv -----
// Shared types and constants for the JSON string escaper.
`default_nettype none

package jse_pkg;

    // Width of the running output byte counter
    localparam int COUNT_WIDTH = 32;

    // Width of the reported byte total
    localparam int TOTAL_WIDTH = 32;

    // Depth of the descriptor queue between the front and the back
    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

    // Input command codes
    localparam logic CMD_CHAR = 1'b0;
    localparam logic CMD_END  = 1'b1;

    // ASCII codes used by the front or the back
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_U      = 8'h75;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_B      = 8'h62;
    localparam logic [7:0] CH_F      = 8'h66;
    localparam logic [7:0] CH_N      = 8'h6E;
    localparam logic [7:0] CH_R      = 8'h72;
    localparam logic [7:0] CH_T      = 8'h74;

    // What the back has to emit for one item
    typedef enum logic [1:0] {
        KIND_PLAIN,   // one byte, passed through
        KIND_ESC2,    // backslash plus escape letter
        KIND_UNI,     // \u00xx form
        KIND_END      // closing quote with byte total
    } kind_t;

    // One classified item
    typedef struct packed {
        logic       open;   // opening quote goes first
        kind_t      kind;
        logic [7:0] data;   // plain byte, escape letter or raw control byte
    } desc_t;

endpackage

`default_nettype wire

// ----- rtl/jse_front.sv -----
// Front end: classifies each input item and tracks whether a string is open.
`default_nettype none

module jse_front (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           push,
    input  wire logic           command,
    input  wire logic [7:0]     char_byte,
    input  wire logic           q_full,
    output jse_pkg::desc_t      q_desc,
    output logic                q_push
);

    logic string_open_reg;
    logic string_open_next;
    logic accept;
    logic [7:0] esc_letter;
    logic       is_esc;

    assign accept = push && !q_full;

    // Two-byte escape lookup
    always_comb
    begin
        is_esc     = 1'b1;
        esc_letter = char_byte;
        case (char_byte)
            jse_pkg::CH_QUOTE:  esc_letter = jse_pkg::CH_QUOTE;
            jse_pkg::CH_BSLASH: esc_letter = jse_pkg::CH_BSLASH;
            8'h08:              esc_letter = jse_pkg::CH_B;
            8'h0C:              esc_letter = jse_pkg::CH_F;
            8'h0A:              esc_letter = jse_pkg::CH_N;
            8'h0D:              esc_letter = jse_pkg::CH_R;
            8'h09:              esc_letter = jse_pkg::CH_T;
            default:            is_esc = 1'b0;
        endcase
    end

    // Build the descriptor
    always_comb
    begin
        q_desc.open = !string_open_reg;
        q_desc.data = char_byte;
        if (command == jse_pkg::CMD_END)
        begin
            q_desc.kind = jse_pkg::KIND_END;
        end
        else if (is_esc)
        begin
            q_desc.kind = jse_pkg::KIND_ESC2;
            q_desc.data = esc_letter;
        end
        else if (char_byte < 8'd32)
        begin
            q_desc.kind = jse_pkg::KIND_UNI;
        end
        else
        begin
            q_desc.kind = jse_pkg::KIND_PLAIN;
        end
    end

    assign q_push = accept;

    // A character opens the string, the end command closes it
    assign string_open_next = accept ? (command == jse_pkg::CMD_CHAR) : string_open_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            string_open_reg <= 1'b0;
        end
        else
        begin
            string_open_reg <= string_open_next;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/jse_queue.sv -----
// Short descriptor queue between the front and the back.
`default_nettype none

module jse_queue (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           wr_en,
    input  wire jse_pkg::desc_t wr_desc,
    output logic                full,
    input  wire logic           rd_en,
    output jse_pkg::desc_t      rd_desc,
    output logic                rd_valid
);

    jse_pkg::desc_t entry_reg [jse_pkg::QUEUE_DEPTH];
    logic [jse_pkg::QUEUE_PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [jse_pkg::QUEUE_PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [jse_pkg::QUEUE_CNT_W-1:0] count_reg, count_next;
    logic do_wr, do_rd;

    localparam logic [jse_pkg::QUEUE_PTR_W-1:0] LastPtr =
        jse_pkg::QUEUE_PTR_W'(jse_pkg::QUEUE_DEPTH - 1);
    localparam logic [jse_pkg::QUEUE_CNT_W-1:0] FullCount =
        jse_pkg::QUEUE_CNT_W'(jse_pkg::QUEUE_DEPTH);

    assign full     = (count_reg == FullCount);
    assign rd_valid = (count_reg != '0);
    assign rd_desc  = entry_reg[rd_ptr_reg];
    assign do_wr    = wr_en && !full;
    assign do_rd    = rd_en && rd_valid;

    // Pointer and fill count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr)
        begin
            wr_ptr_next = (wr_ptr_reg == LastPtr) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_rd)
        begin
            rd_ptr_next = (rd_ptr_reg == LastPtr) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_wr && !do_rd)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_rd && !do_wr)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage
    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            entry_reg[wr_ptr_reg] <= wr_desc;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/jse_back.sv -----
// Back end: expands descriptors into output bytes, counts them, holds the result register.
`default_nettype none

module jse_back (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire jse_pkg::desc_t             q_desc,
    input  wire logic                       q_valid,
    output logic                            q_pop,
    output logic                            empty,
    input  wire logic                       pop,
    output logic [7:0]                      out_byte,
    output logic                            last_of_run,
    output logic [jse_pkg::TOTAL_WIDTH-1:0] total_bytes
);

    localparam int ExtW = 65;
    localparam logic [jse_pkg::COUNT_WIDTH-1:0] CountMax = '1;
    localparam logic [ExtW-1:0] TotalMax = {{(ExtW - jse_pkg::TOTAL_WIDTH){1'b0}},
                                            {jse_pkg::TOTAL_WIDTH{1'b1}}};

    logic [2:0] idx_reg, idx_next;
    logic [jse_pkg::COUNT_WIDTH-1:0] cnt_reg, cnt_next, cnt_inc;
    logic out_valid_reg, out_valid_next;
    logic [7:0] out_byte_reg;
    logic       out_last_reg;
    logic [jse_pkg::TOTAL_WIDTH-1:0] out_total_reg;

    logic [2:0] base_len, run_len, seq_pos;
    logic       is_last, take, load;
    logic [7:0] sel_byte;
    logic [jse_pkg::TOTAL_WIDTH-1:0] sel_total;
    logic [ExtW-1:0] cnt_ext;

    function automatic logic [7:0] hex_digit(input logic [3:0] nib);
        if (nib < 4'd10)
        begin
            hex_digit = jse_pkg::CH_ZERO + {4'd0, nib};
        end
        else
        begin
            hex_digit = 8'h57 + {4'd0, nib};
        end
    endfunction

    assign take = pop && out_valid_reg;
    assign load = q_valid && (!out_valid_reg || take);

    // Run length and position inside the current item
    always_comb
    begin
        case (q_desc.kind)
            jse_pkg::KIND_PLAIN: base_len = 3'd1;
            jse_pkg::KIND_ESC2:  base_len = 3'd2;
            jse_pkg::KIND_UNI:   base_len = 3'd6;
            jse_pkg::KIND_END:   base_len = 3'd1;
            default:             base_len = 3'd1;
        endcase
        run_len = base_len + {2'd0, q_desc.open};
        seq_pos = idx_reg - {2'd0, q_desc.open};
        is_last = (idx_reg == run_len - 3'd1);
    end

    // Byte selection
    always_comb
    begin
        sel_byte = jse_pkg::CH_QUOTE;
        if (!(q_desc.open && idx_reg == 3'd0))
        begin
            case (q_desc.kind)
                jse_pkg::KIND_PLAIN: sel_byte = q_desc.data;
                jse_pkg::KIND_ESC2:
                    sel_byte = (seq_pos == 3'd0) ? jse_pkg::CH_BSLASH : q_desc.data;
                jse_pkg::KIND_UNI:
                begin
                    case (seq_pos)
                        3'd0:    sel_byte = jse_pkg::CH_BSLASH;
                        3'd1:    sel_byte = jse_pkg::CH_U;
                        3'd2:    sel_byte = jse_pkg::CH_ZERO;
                        3'd3:    sel_byte = jse_pkg::CH_ZERO;
                        3'd4:    sel_byte = hex_digit(q_desc.data[7:4]);
                        default: sel_byte = hex_digit(q_desc.data[3:0]);
                    endcase
                end
                jse_pkg::KIND_END:   sel_byte = jse_pkg::CH_QUOTE;
                default:             sel_byte = q_desc.data;
            endcase
        end
    end

    // Saturating counter and the reported total
    always_comb
    begin
        cnt_inc = (cnt_reg == CountMax) ? cnt_reg : cnt_reg + 1'b1;
        cnt_ext = {{(ExtW - jse_pkg::COUNT_WIDTH){1'b0}}, cnt_inc};
        if (q_desc.kind == jse_pkg::KIND_END && is_last)
        begin
            sel_total = (cnt_ext > TotalMax) ? '1 : cnt_ext[jse_pkg::TOTAL_WIDTH-1:0];
        end
        else
        begin
            sel_total = '0;
        end
    end

    // Sequencer and output register control
    always_comb
    begin
        idx_next       = idx_reg;
        cnt_next       = cnt_reg;
        out_valid_next = out_valid_reg;
        q_pop          = 1'b0;
        if (take)
        begin
            out_valid_next = 1'b0;
        end
        if (load)
        begin
            out_valid_next = 1'b1;
            if (is_last)
            begin
                idx_next = 3'd0;
                q_pop    = 1'b1;
            end
            else
            begin
                idx_next = idx_reg + 3'd1;
            end
            if (q_desc.kind == jse_pkg::KIND_END && is_last)
            begin
                cnt_next = '0;
            end
            else
            begin
                cnt_next = cnt_inc;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg       <= 3'd0;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            idx_reg       <= idx_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Result payload
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            out_byte_reg  <= sel_byte;
            out_last_reg  <= is_last;
            out_total_reg <= sel_total;
        end
    end

    assign empty       = !out_valid_reg;
    assign out_byte    = out_byte_reg;
    assign last_of_run = out_last_reg;
    assign total_bytes = out_total_reg;

endmodule

`default_nettype wire

// ----- rtl/json_string_escaper_top.sv -----
// Top level of the JSON string escaper: front, descriptor queue and back.
//
// Input side is a queue write port: an item (command, char_byte) transfers on
// a clock edge with push high and full low. Output side is a queue read port:
// while empty is low, out_byte, last_of_run and total_bytes show the oldest
// byte, which transfers on an edge with pop high.
// The first byte of an item passes through the descriptor queue and then the
// result register before it is visible. The back emits one byte per cycle while
// the receiver keeps popping; an item produces 1 byte for a plain byte, 2 for a
// two-byte escape, 6 for a \u00xx escape, 1 for the end command, plus 1 when the
// opening quote goes first. A two-entry descriptor queue lets the input keep
// taking items while a long escape is being expanded; full rises only when
// that queue is full.
// When the receiver stalls the result register holds, the queue fills and
// full rises; nothing is dropped.
// Reset (rst_n low, asynchronous) empties the queue and result register,
// clears the byte counter and closes any open string.
`default_nettype none

module json_string_escaper_top (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        push,
    output logic             full,
    input  wire logic        command,
    input  wire logic [7:0]  char_byte,
    output logic             empty,
    input  wire logic        pop,
    output logic [7:0]       out_byte,
    output logic             last_of_run,
    output logic [31:0]      total_bytes
);

    jse_pkg::desc_t front_desc;
    jse_pkg::desc_t head_desc;
    logic front_push;
    logic q_full;
    logic head_valid;
    logic head_pop;

    assign full = q_full;

    jse_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .command   (command),
        .char_byte (char_byte),
        .q_full    (q_full),
        .q_desc    (front_desc),
        .q_push    (front_push)
    );

    jse_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (front_push),
        .wr_desc  (front_desc),
        .full     (q_full),
        .rd_en    (head_pop),
        .rd_desc  (head_desc),
        .rd_valid (head_valid)
    );

    jse_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_desc      (head_desc),
        .q_valid     (head_valid),
        .q_pop       (head_pop),
        .empty       (empty),
        .pop         (pop),
        .out_byte    (out_byte),
        .last_of_run (last_of_run),
        .total_bytes (total_bytes)
    );

endmodule

`default_nettype wire

// ----- rtl/jse_checker.sv -----
// Port-level checks for the JSON string escaper, bound to the top level.
`default_nettype none

module jse_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        push,
    input wire logic        full,
    input wire logic        empty,
    input wire logic        pop,
    input wire logic [7:0]  out_byte,
    input wire logic        last_of_run,
    input wire logic [31:0] total_bytes
);

    // Reset leaves both sides idle
    a_reset_idle: assert property (@(posedge clk) !rst_n |-> (empty && !full))
        else $error("block not idle in reset");

    // Without a push the input side cannot fill up
    a_full_needs_push: assert property (@(posedge clk) disable iff (!rst_n)
        (!full && !push) |=> !full)
        else $error("full rose without a transfer");

    // A stalled result holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> (!empty && $stable(out_byte) && $stable(last_of_run)
                              && $stable(total_bytes)))
        else $error("stalled result changed");

    // A byte total only comes with a closing quote at the end of a run
    a_total_on_close: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && total_bytes != 32'd0) |-> (last_of_run && out_byte == 8'h22))
        else $error("byte total outside a closing quote");

    // A closed string has at least its two quotes
    a_total_min: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && total_bytes != 32'd0) |-> (total_bytes >= 32'd2))
        else $error("byte total below two");

endmodule

bind json_string_escaper_top jse_checker u_jse_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .push        (push),
    .full        (full),
    .empty       (empty),
    .pop         (pop),
    .out_byte    (out_byte),
    .last_of_run (last_of_run),
    .total_bytes (total_bytes)
);

`default_nettype wire

// ----- bench/tb_top.sv -----
// Self-checking bench for the JSON string escaper: random strings in, escaped bytes out.
`timescale 1ns / 1ps

module tb_top;

    // Control bytes that get a short escape letter
    localparam logic [7:0] CTL_BS  = 8'h08;
    localparam logic [7:0] CTL_TAB = 8'h09;
    localparam logic [7:0] CTL_LF  = 8'h0A;
    localparam logic [7:0] CTL_FF  = 8'h0C;
    localparam logic [7:0] CTL_CR  = 8'h0D;
    localparam logic [7:0] CH_LOWER_A = 8'h61;
    localparam logic [7:0] CTL_LIMIT  = 8'h20;

    localparam int RANDOM_ITEMS = 185;
    localparam int TAIL_ITEMS   = 25;
    localparam int HOLD_CYCLES  = 150;
    localparam int HOLD_AFTER   = 60;
    localparam int DRAIN_CYCLES = 20;
    localparam int QUIET_LIMIT  = 3000;
    localparam int MAX_REPORTS  = 10;

    typedef struct {
        logic       cmd;
        logic [7:0] ch;
    } str_item_t;

    typedef struct {
        logic [7:0]  ob;
        logic        lst;
        logic [31:0] tot;
    } esc_byte_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b1;
    logic        push = 1'b0;
    logic        full;
    logic        command = jse_pkg::CMD_CHAR;
    logic [7:0]  char_byte = 8'h00;
    logic        empty;
    logic        pop = 1'b0;
    logic [7:0]  out_byte;
    logic        last_of_run;
    logic [31:0] total_bytes;

    str_item_t pending_chars[$];
    esc_byte_t escaped_bytes[$];

    // Predictor state
    logic                            str_open = 1'b0;
    logic [jse_pkg::COUNT_WIDTH-1:0] bytes_emitted = '0;

    // Driver and monitor bookkeeping
    int  send_gap = 0;
    int  recv_gap = 0;
    int  hold_left = 0;
    bit  send_noisy = 1'b1;
    bit  recv_noisy = 1'b1;
    bit  tail_phase = 1'b0;
    bit  recv_hold = 1'b0;
    bit  pressure_done = 1'b0;
    int  items_sent = 0;
    int  bytes_checked = 0;
    int  full_stalls = 0;
    int  mismatches = 0;
    int  quiet_cycles = 0;
    int  strings_closed = 0;
    int  short_escapes = 0;
    int  hex_escapes = 0;

    json_string_escaper_top u_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (push),
        .full        (full),
        .command     (command),
        .char_byte   (char_byte),
        .empty       (empty),
        .pop         (pop),
        .out_byte    (out_byte),
        .last_of_run (last_of_run),
        .total_bytes (total_bytes)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    function automatic logic [7:0] hex_digit(input logic [3:0] nib);
        if (nib < 4'd10)
            return jse_pkg::CH_ZERO + 8'(nib);
        else
            return CH_LOWER_A + 8'(nib) - 8'd10;
    endfunction

    // Expected escaped bytes for one accepted item, appended in order
    task automatic escape_predict(input logic cmd, input logic [7:0] ch);
        esc_byte_t   run_q[$];
        esc_byte_t   rec;
        logic [7:0]  letter;
        longint unsigned sat;
        begin
            rec.lst = 1'b0;
            rec.tot = '0;
            letter  = 8'h00;
            if (!str_open)
            begin
                rec.ob = jse_pkg::CH_QUOTE;
                run_q.push_back(rec);
                str_open = 1'b1;
            end
            if (cmd == jse_pkg::CMD_END)
            begin
                rec.ob = jse_pkg::CH_QUOTE;
                run_q.push_back(rec);
                strings_closed++;
            end
            else
            begin
                case (ch)
                    jse_pkg::CH_QUOTE:  letter = jse_pkg::CH_QUOTE;
                    jse_pkg::CH_BSLASH: letter = jse_pkg::CH_BSLASH;
                    CTL_BS:             letter = jse_pkg::CH_B;
                    CTL_FF:             letter = jse_pkg::CH_F;
                    CTL_LF:             letter = jse_pkg::CH_N;
                    CTL_CR:             letter = jse_pkg::CH_R;
                    CTL_TAB:            letter = jse_pkg::CH_T;
                    default:            letter = 8'h00;
                endcase
                if (letter != 8'h00)
                begin
                    rec.ob = jse_pkg::CH_BSLASH; run_q.push_back(rec);
                    rec.ob = letter;             run_q.push_back(rec);
                    short_escapes++;
                end
                else if (ch < CTL_LIMIT)
                begin
                    rec.ob = jse_pkg::CH_BSLASH; run_q.push_back(rec);
                    rec.ob = jse_pkg::CH_U;      run_q.push_back(rec);
                    rec.ob = jse_pkg::CH_ZERO;   run_q.push_back(rec);
                    rec.ob = jse_pkg::CH_ZERO;   run_q.push_back(rec);
                    rec.ob = hex_digit(ch[7:4]); run_q.push_back(rec);
                    rec.ob = hex_digit(ch[3:0]); run_q.push_back(rec);
                    hex_escapes++;
                end
                else
                begin
                    rec.ob = ch;
                    run_q.push_back(rec);
                end
            end
            // Saturating count of every byte this string produced
            foreach (run_q[i])
                if (bytes_emitted != '1)
                    bytes_emitted++;
            if (cmd == jse_pkg::CMD_END)
            begin
                sat = longint'(bytes_emitted);
                if (sat > 64'hFFFF_FFFF)
                    sat = 64'hFFFF_FFFF;
                run_q[run_q.size()-1].tot = sat[31:0];
                str_open = 1'b0;
                bytes_emitted = '0;
            end
            run_q[run_q.size()-1].lst = 1'b1;
            foreach (run_q[i])
                escaped_bytes.push_back(run_q[i]);
        end
    endtask

    task automatic add_item(input logic cmd, input logic [7:0] ch);
        str_item_t it;
        begin
            it.cmd = cmd;
            it.ch  = ch;
            pending_chars.push_back(it);
        end
    endtask

    // Mix of printable, control, escape and fully random bytes
    function automatic logic [7:0] pick_char();
        logic [7:0] picks[7];
        begin
            picks = '{jse_pkg::CH_QUOTE, jse_pkg::CH_BSLASH, CTL_BS, CTL_FF, CTL_LF,
                      CTL_CR, CTL_TAB};
            case ($urandom_range(0, 9))
                0, 1, 2, 3: return 8'($urandom_range(32, 126));
                4, 5:       return 8'($urandom_range(0, 31));
                6:          return picks[$urandom_range(0, 6)];
                default:    return 8'($urandom_range(0, 255));
            endcase
        end
    endfunction

    // Driver: presents the head of the pending queue, with random gaps
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            push      <= 1'b0;
            command   <= jse_pkg::CMD_CHAR;
            char_byte <= 8'h00;
        end
        else
        begin
            if (push && !full)
            begin
                escape_predict(command, char_byte);
                void'(pending_chars.pop_front());
                items_sent <= items_sent + 1;
            end
            if (push && full)
                full_stalls <= full_stalls + 1;
            if ($urandom_range(0, 39) == 0)
                send_noisy = !send_noisy;
            if (send_gap == 0 && send_noisy && !tail_phase && !recv_hold
                && $urandom_range(0, 5) == 0)
                send_gap = $urandom_range(1, 19);
            if (send_gap != 0 || pending_chars.size() == 0)
            begin
                if (send_gap != 0)
                    send_gap--;
                push      <= 1'b0;
                char_byte <= 8'($urandom_range(0, 255));
            end
            else
            begin
                push      <= 1'b1;
                command   <= pending_chars[0].cmd;
                char_byte <= pending_chars[0].ch;
            end
            tail_phase <= (pending_chars.size() < TAIL_ITEMS);
        end
    end

    // Monitor: checks each transfer and throttles pop
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pop <= 1'b0;
        end
        else
        begin
            if (pop && !empty)
            begin
                bytes_checked <= bytes_checked + 1;
                if (escaped_bytes.size() == 0)
                begin
                    mismatches <= mismatches + 1;
                    if (mismatches < MAX_REPORTS)
                        $display("[%0t] unexpected byte %02h last=%0b total=%0d", $realtime,
                                 out_byte, last_of_run, total_bytes);
                end
                else if (out_byte !== escaped_bytes[0].ob
                         || last_of_run !== escaped_bytes[0].lst
                         || total_bytes !== escaped_bytes[0].tot)
                begin
                    mismatches <= mismatches + 1;
                    if (mismatches < MAX_REPORTS)
                        $display("[%0t] exp %02h/%0b/%0d got %02h/%0b/%0d (byte/last/total)",
                                 $realtime, escaped_bytes[0].ob, escaped_bytes[0].lst,
                                 escaped_bytes[0].tot, out_byte, last_of_run, total_bytes);
                    void'(escaped_bytes.pop_front());
                end
                else
                begin
                    void'(escaped_bytes.pop_front());
                end
            end
            // One long hold-off so the block backs up and raises full
            if (hold_left != 0)
            begin
                hold_left--;
                if (hold_left == 0)
                    pressure_done <= 1'b1;
                pop <= 1'b0;
            end
            else if (!pressure_done && items_sent >= HOLD_AFTER)
            begin
                hold_left = HOLD_CYCLES;
                pop <= 1'b0;
            end
            else
            begin
                if ($urandom_range(0, 39) == 0)
                    recv_noisy = !recv_noisy;
                if (recv_gap == 0 && recv_noisy && !tail_phase && $urandom_range(0, 5) == 0)
                    recv_gap = $urandom_range(1, 19);
                if (recv_gap != 0)
                begin
                    recv_gap--;
                    pop <= 1'b0;
                end
                else
                begin
                    pop <= 1'b1;
                end
            end
            recv_hold <= (hold_left != 0);
        end
    end

    // Watchdog on cycles with no transfer on either side
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((push && !full) || (pop && !empty))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("Timeout: no transfer for %0d cycles", quiet_cycles);
                $display("Verification failed");
                $finish;
            end
        end
    end

    // Stimulus, reset and end of run
    initial
    begin
        int n_rand;
        int len;
        n_rand = 0;
        len    = 0;
        rst_n <= 1'b0;

        // Directed: empty string, every escape, field extremes
        add_item(jse_pkg::CMD_END, 8'h00);
        add_item(jse_pkg::CMD_CHAR, 8'h00);
        add_item(jse_pkg::CMD_CHAR, 8'h1F);
        add_item(jse_pkg::CMD_CHAR, CTL_BS);
        add_item(jse_pkg::CMD_CHAR, CTL_FF);
        add_item(jse_pkg::CMD_CHAR, CTL_LF);
        add_item(jse_pkg::CMD_CHAR, CTL_CR);
        add_item(jse_pkg::CMD_CHAR, CTL_TAB);
        add_item(jse_pkg::CMD_CHAR, jse_pkg::CH_QUOTE);
        add_item(jse_pkg::CMD_CHAR, jse_pkg::CH_BSLASH);
        add_item(jse_pkg::CMD_CHAR, 8'h20);
        add_item(jse_pkg::CMD_CHAR, 8'h7F);
        add_item(jse_pkg::CMD_CHAR, 8'h80);
        add_item(jse_pkg::CMD_CHAR, 8'hFF);
        add_item(jse_pkg::CMD_CHAR, 8'h01);
        add_item(jse_pkg::CMD_CHAR, 8'h10);
        add_item(jse_pkg::CMD_END, 8'h5A);
        add_item(jse_pkg::CMD_END, 8'hFF);
        add_item(jse_pkg::CMD_CHAR, 8'h41);
        add_item(jse_pkg::CMD_END, 8'h00);
        add_item(jse_pkg::CMD_CHAR, 8'h0B);
        add_item(jse_pkg::CMD_END, 8'h22);

        // Random strings, mostly short, some long
        while (n_rand < RANDOM_ITEMS)
        begin
            if ($urandom_range(0, 9) == 0)
                len = $urandom_range(30, 60);
            else
                len = $urandom_range(0, 12);
            repeat (len)
                add_item(jse_pkg::CMD_CHAR, pick_char());
            add_item(jse_pkg::CMD_END, 8'($urandom_range(0, 255)));
            n_rand += len + 1;
        end

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        while (pending_chars.size() != 0)
            @(posedge clk);
        while (escaped_bytes.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Sent %0d items in %0d strings (%0d short escapes, %0d hex escapes)",
                 items_sent, strings_closed, short_escapes, hex_escapes);
        $display("Checked %0d output bytes; input held off %0d cycles; %0d mismatches",
                 bytes_checked, full_stalls, mismatches);
        if (mismatches == 0 && escaped_bytes.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
